### rtl/lz77td_pkg.sv
// ----------------------------------------------------------------------------
// lz77td_pkg
// Shared types and constants for the LZ77 byte-token decompressor.
// ----------------------------------------------------------------------------
package lz77td_pkg;

  // History window and byte counter
  localparam int unsigned HIST_DEPTH = 65536;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);
  localparam int unsigned CNT_W      = 25;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] LEN_RESET = 25'd16777216;

  // Result packing
  localparam int unsigned BYTES_PER_RESULT = 8;
  localparam int unsigned DATA_W           = 8 * BYTES_PER_RESULT;
  localparam int unsigned BCNT_W           = $clog2(BYTES_PER_RESULT + 1);
  localparam int unsigned BSEL_W           = (BYTES_PER_RESULT > 1) ?
                                             $clog2(BYTES_PER_RESULT) : 1;

  // Token coding
  localparam logic [1:0] OFF_HIGH_EXT = 2'b11;  // offset high byte follows
  localparam int unsigned MATCH_BIAS  = 2;      // match copies M+2 bytes
  localparam int unsigned MLEN_W      = 9;      // holds 255 + 2

  typedef enum logic [2:0] {
    PH_TOKEN    = 3'd0,
    PH_LITLEN   = 3'd1,
    PH_MATCHLEN = 3'd2,
    PH_LITERALS = 3'd3,
    PH_OFFLOW   = 3'd4,
    PH_OFFHIGH  = 3'd5
  } phase_t;

  typedef enum logic {
    CT_IDLE = 1'b0,
    CT_COPY = 1'b1
  } ctl_t;

endpackage

### rtl/lz77_token_decompressor_top.sv
// ----------------------------------------------------------------------------
// lz77_token_decompressor_top
// Byte-token LZ77 decompressor with a 64 KiB history memory; results carry
// up to eight decompressed bytes each.
// ----------------------------------------------------------------------------
// Order: a byte that causes a single result is held in the packer register,
//   then moved to the output register that drives out_valid; the results of an
//   N-byte match are packed from history reads issued after its last offset byte.
// Throughput: a new byte is taken only while no copy runs and no closed result
//   waits in the packer; a match is set by the one history read port and one
//   byte pushed into the result packer per cycle while the packer is not held.
// Reset: synchronous, active low; clears the parser, counters and flags.
//   The history memory is not cleared and needs no clearing pass.
module lz77_token_decompressor_top
  import lz77td_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data,
  output logic [3:0]        out_count,
  output logic              out_last,
  output logic              out_done,
  output logic              out_error,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data
);

  // Configuration and parser state
  logic [CNT_W-1:0]  out_len_r;
  ctl_t              ctl_r, ctl_nxt;
  phase_t            phase_r, phase_nxt;
  logic [7:0]        tok_r, tok_nxt;
  logic [7:0]        lit_r, lit_nxt;
  logic [7:0]        mf_r, mf_nxt;
  logic [7:0]        offl_r, offl_nxt;
  logic [CNT_W-1:0]  bw_r, bw_nxt;
  logic              done_r, done_nxt;
  logic              err_r, err_nxt;

  // Copy engine
  logic [HIST_AW-1:0] off_r, off_nxt;
  logic [MLEN_W-1:0]  n_issue_r, n_issue_nxt;
  logic [MLEN_W-1:0]  n_push_r, n_push_nxt;
  logic               b_vld_r, b_vld_nxt;
  logic               fwd_r, fwd_nxt;
  logic [7:0]         fwd_byte_r, fwd_byte_nxt;
  logic               done_pend_r, done_pend_nxt;

  // Result packer and output register
  logic [DATA_W-1:0]  pk_data_r, pk_data_nxt;
  logic [BCNT_W-1:0]  pk_cnt_r, pk_cnt_nxt;
  logic               pk_closed_r, pk_closed_nxt;
  logic               pk_last_r, pk_last_nxt;
  logic               pk_done_r, pk_done_nxt;
  logic               pk_err_r, pk_err_nxt;
  logic               out_valid_r;
  logic [DATA_W-1:0]  out_data_r;
  logic [BCNT_W-1:0]  out_count_r;
  logic               out_last_r, out_done_r, out_error_r;

  // History memory ports
  logic [7:0]         hist_mem [HIST_DEPTH];
  logic               wr_en;
  logic [HIST_AW-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic               rd_en;
  logic [HIST_AW-1:0] rd_addr;
  logic [7:0]         mem_q_r;

  logic               in_fire, out_mv, push_ok, adv, issue;
  logic [CNT_W-1:0]   bw_inc;
  logic [7:0]         byte_b;

  assign in_ready = (ctl_r == CT_IDLE) && !pk_closed_r;
  assign in_fire  = in_valid && in_ready;
  assign out_mv   = pk_closed_r && (!out_valid_r || out_ready);
  assign bw_inc   = (bw_r == CNT_MAX) ? bw_r : bw_r + 1'b1;

  assign push_ok  = !pk_closed_r;
  assign adv      = (ctl_r == CT_COPY) && b_vld_r && push_ok;
  assign issue    = (ctl_r == CT_COPY) && (n_issue_r != '0) && (!b_vld_r || adv);
  assign byte_b   = fwd_r ? fwd_byte_r : mem_q_r;
  assign rd_en    = issue;
  assign rd_addr  = (adv ? bw_inc[HIST_AW-1:0] : bw_r[HIST_AW-1:0]) - off_r;

  // History memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q_r <= hist_mem[rd_addr];
    end
  end

  // Parse, copy and pack
  always_comb begin
    logic              fk, al, put, go;
    logic [7:0]        hi;
    logic [HIST_AW-1:0] mo;
    logic [CNT_W-1:0]  bw_chk;
    logic [CNT_W:0]    bw_sum;
    logic [MLEN_W-1:0] mlen;

    fk = 1'b0; al = 1'b0; put = 1'b0; go = 1'b0;
    hi = 8'd0;
    mo = '0;
    bw_chk = bw_r;
    bw_sum = '0;
    mlen = '0;

    ctl_nxt = ctl_r;       phase_nxt = phase_r;
    tok_nxt = tok_r;       lit_nxt = lit_r;
    mf_nxt = mf_r;         offl_nxt = offl_r;
    bw_nxt = bw_r;         done_nxt = done_r;
    err_nxt = err_r;
    off_nxt = off_r;       n_issue_nxt = n_issue_r;
    n_push_nxt = n_push_r; b_vld_nxt = b_vld_r;
    fwd_nxt = fwd_r;       fwd_byte_nxt = fwd_byte_r;
    done_pend_nxt = done_pend_r;
    pk_data_nxt = pk_data_r;     pk_cnt_nxt = pk_cnt_r;
    pk_closed_nxt = pk_closed_r; pk_last_nxt = pk_last_r;
    pk_done_nxt = pk_done_r;     pk_err_nxt = pk_err_r;
    wr_en = 1'b0;
    wr_addr = bw_r[HIST_AW-1:0];
    wr_data = in_byte;

    // Decode one compressed byte
    if (in_fire) begin
      if (!err_r && !done_r) begin
        case (phase_r)
          PH_TOKEN: begin
            tok_nxt = in_byte;
            lit_nxt = {6'd0, in_byte[1:0]};
            mf_nxt  = {4'd0, in_byte[7:4]};
            if (in_byte[1:0] == 2'd0) begin
              phase_nxt = PH_LITLEN;
            end else if (in_byte[7:4] == 4'd0) begin
              phase_nxt = PH_MATCHLEN;
            end else begin
              fk = 1'b1;
            end
          end
          PH_LITLEN: begin
            lit_nxt = in_byte;
            if (mf_r == 8'd0) begin
              phase_nxt = PH_MATCHLEN;
            end else begin
              fk = 1'b1;
            end
          end
          PH_MATCHLEN: begin
            mf_nxt = in_byte;
            fk = 1'b1;
          end
          PH_LITERALS: begin
            put = 1'b1;
            bw_chk = bw_inc;
            lit_nxt = lit_r - 8'd1;
            if (lit_nxt == 8'd0) begin
              al = 1'b1;
            end
          end
          PH_OFFLOW: begin
            offl_nxt = in_byte;
            if (tok_r[3:2] == OFF_HIGH_EXT) begin
              phase_nxt = PH_OFFHIGH;
            end else begin
              hi = {6'd0, tok_r[3:2]};
              go = 1'b1;
            end
          end
          PH_OFFHIGH: begin
            hi = in_byte;
            go = 1'b1;
          end
          default: begin
            phase_nxt = PH_TOKEN;
          end
        endcase

        // Field lengths known: count down the first literal
        if (fk) begin
          if (lit_nxt == 8'd0) begin
            err_nxt = 1'b1;
          end else begin
            lit_nxt = lit_nxt - 8'd1;
            if (lit_nxt != 8'd0) begin
              phase_nxt = PH_LITERALS;
            end else begin
              al = 1'b1;
            end
          end
        end

        // Literals finished: go to offset or end the token
        if (al) begin
          if (mf_nxt != 8'd0) begin
            phase_nxt = PH_OFFLOW;
          end else begin
            phase_nxt = PH_TOKEN;
            if (bw_chk >= out_len_r) begin
              done_nxt = 1'b1;
            end
          end
        end

        // Check the offset and start the copy
        if (go) begin
          mo = {hi, offl_nxt};
          if ((mo == '0) || ({{(CNT_W-HIST_AW){1'b0}}, mo} > bw_r)) begin
            err_nxt = 1'b1;
            go = 1'b0;
          end else begin
            mlen = {1'b0, mf_r} + MLEN_W'(MATCH_BIAS);
            bw_sum = {1'b0, bw_r} + {{(CNT_W+1-MLEN_W){1'b0}}, mlen};
            done_pend_nxt = (bw_sum > {1'b0, CNT_MAX}) ? 1'b1 :
                            (bw_sum[CNT_W-1:0] >= out_len_r);
            phase_nxt   = PH_TOKEN;
            off_nxt     = mo;
            n_issue_nxt = mlen;
            n_push_nxt  = mlen;
            b_vld_nxt   = 1'b0;
            fwd_nxt     = 1'b0;
            ctl_nxt     = CT_COPY;
          end
        end

        // Store a literal
        if (put) begin
          wr_en  = 1'b1;
          bw_nxt = bw_inc;
        end
      end

      // Single-result step: close the packer at once
      if (!go) begin
        pk_data_nxt   = put ? {{(DATA_W-8){1'b0}}, in_byte} : '0;
        pk_cnt_nxt    = put ? BCNT_W'(1) : '0;
        pk_closed_nxt = 1'b1;
        pk_last_nxt   = 1'b1;
        pk_done_nxt   = done_nxt;
        pk_err_nxt    = err_nxt;
      end
    end

    // Issue history reads for the copy
    if (issue) begin
      n_issue_nxt  = n_issue_r - 1'b1;
      b_vld_nxt    = 1'b1;
      fwd_nxt      = adv && (rd_addr == bw_r[HIST_AW-1:0]);
      fwd_byte_nxt = byte_b;
    end else if (adv) begin
      b_vld_nxt = 1'b0;
    end

    // Write back the copied byte and push it into the packer
    if (adv) begin
      wr_en   = 1'b1;
      wr_data = byte_b;
      bw_nxt  = bw_inc;
      pk_data_nxt = pk_data_r |
                    ({{(DATA_W-8){1'b0}}, byte_b} << {pk_cnt_r[BSEL_W-1:0], 3'b000});
      pk_cnt_nxt  = pk_cnt_r + 1'b1;
      pk_done_nxt = done_pend_r;
      pk_err_nxt  = err_r;
      n_push_nxt  = n_push_r - 1'b1;
      if (n_push_r == MLEN_W'(1)) begin
        pk_closed_nxt = 1'b1;
        pk_last_nxt   = 1'b1;
        done_nxt      = done_pend_r;
        ctl_nxt       = CT_IDLE;
      end else if (pk_cnt_r == BCNT_W'(BYTES_PER_RESULT - 1)) begin
        pk_closed_nxt = 1'b1;
        pk_last_nxt   = 1'b0;
      end
    end

    // Hand a closed result to the output register
    if (out_mv) begin
      pk_data_nxt   = '0;
      pk_cnt_nxt    = '0;
      pk_closed_nxt = 1'b0;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_len_r   <= LEN_RESET;
      ctl_r       <= CT_IDLE;
      phase_r     <= PH_TOKEN;
      tok_r       <= '0;
      lit_r       <= '0;
      mf_r        <= '0;
      offl_r      <= '0;
      bw_r        <= '0;
      done_r      <= 1'b0;
      err_r       <= 1'b0;
      n_issue_r   <= '0;
      n_push_r    <= '0;
      b_vld_r     <= 1'b0;
      fwd_r       <= 1'b0;
      done_pend_r <= 1'b0;
      pk_data_r   <= '0;
      pk_cnt_r    <= '0;
      pk_closed_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        out_len_r <= cfg_wr_data;
      end
      ctl_r       <= ctl_nxt;
      phase_r     <= phase_nxt;
      tok_r       <= tok_nxt;
      lit_r       <= lit_nxt;
      mf_r        <= mf_nxt;
      offl_r      <= offl_nxt;
      bw_r        <= bw_nxt;
      done_r      <= done_nxt;
      err_r       <= err_nxt;
      n_issue_r   <= n_issue_nxt;
      n_push_r    <= n_push_nxt;
      b_vld_r     <= b_vld_nxt;
      fwd_r       <= fwd_nxt;
      done_pend_r <= done_pend_nxt;
      pk_data_r   <= pk_data_nxt;
      pk_cnt_r    <= pk_cnt_nxt;
      pk_closed_r <= pk_closed_nxt;
      if (out_mv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    fwd_byte_r <= fwd_byte_nxt;
    pk_last_r  <= pk_last_nxt;
    pk_done_r  <= pk_done_nxt;
    pk_err_r   <= pk_err_nxt;
    if (out_mv) begin
      out_data_r  <= pk_data_r;
      out_count_r <= pk_cnt_r;
      out_last_r  <= pk_last_r;
      out_done_r  <= pk_done_r;
      out_error_r <= pk_err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_count = 4'(out_count_r);
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;
  assign out_error = out_error_r;

endmodule
